/* src/lr_pkg.sv */
// ----------------------------------------------------------------------------
// lr_pkg
// Shared constants, control word layout and microprogram for the line walker.
// ----------------------------------------------------------------------------
`default_nettype none

package lr_pkg;

    localparam int MAX_COORD = 64;
    localparam int COORD_W   = $clog2(MAX_COORD);
    localparam int CFG_W     = 7;
    localparam int CFG_IDX_W = 2;
    localparam int ERR_W     = COORD_W + 3;
    localparam int DY_W      = COORD_W + 1;

    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
    localparam logic [CFG_W-1:0]     WIDTH_RST         = 7'd64;
    localparam logic [CFG_W-1:0]     HEIGHT_RST        = 7'd40;

    typedef logic [1:0] t_step;

    localparam t_step STEP_IDLE  = 2'd0;
    localparam t_step STEP_SETUP = 2'd1;
    localparam t_step STEP_WALK  = 2'd2;

    typedef enum logic [1:0] {
        COND_NEVER,
        COND_NO_START,
        COND_DONE
    } t_cond;

    typedef struct packed {
        logic  ld;
        logic  setup;
        logic  emit;
        logic  walk;
        t_cond cond;
        t_step jmp;
        t_step nxt;
    } t_uword;

    typedef struct packed {
        logic ld;
        logic setup;
        logic emit;
        logic walk;
    } t_ctl;

    typedef struct packed {
        logic done;
    } t_stat;

    function automatic t_uword f_rom(input t_step s);
        t_uword w;
        begin
            w = '{ld: 1'b0, setup: 1'b0, emit: 1'b0, walk: 1'b0,
                  cond: COND_NEVER, jmp: STEP_IDLE, nxt: STEP_IDLE};
            case (s)
                STEP_IDLE: begin
                    w.ld   = 1'b1;
                    w.cond = COND_NO_START;
                    w.jmp  = STEP_IDLE;
                    w.nxt  = STEP_SETUP;
                end
                STEP_SETUP: begin
                    w.setup = 1'b1;
                    w.nxt   = STEP_WALK;
                end
                STEP_WALK: begin
                    w.emit = 1'b1;
                    w.walk = 1'b1;
                    w.cond = COND_DONE;
                    w.jmp  = STEP_IDLE;
                    w.nxt  = STEP_WALK;
                end
                default: begin
                    w.nxt = STEP_IDLE;
                end
            endcase
            return w;
        end
    endfunction

endpackage

`default_nettype wire

/* src/lr_ctrl.sv */
// ----------------------------------------------------------------------------
// lr_ctrl
// Step counter and microprogram table with conditional jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_start,
    input  wire lr_pkg::t_stat i_stat,
    output lr_pkg::t_ctl       o_ctl,
    output logic               o_busy
);
    import lr_pkg::*;

    t_step  r_step;
    t_step  n_step;
    t_uword w_uw;
    logic   w_take;

    assign w_uw = f_rom(r_step);

    always_comb begin
        case (w_uw.cond)
            COND_NEVER:    w_take = 1'b0;
            COND_NO_START: w_take = !i_start;
            COND_DONE:     w_take = i_stat.done;
            default:       w_take = 1'b0;
        endcase
        n_step = w_take ? w_uw.jmp : w_uw.nxt;
    end

    always_comb begin
        o_ctl.ld    = w_uw.ld & i_start;
        o_ctl.setup = w_uw.setup;
        o_ctl.emit  = w_uw.emit;
        o_ctl.walk  = w_uw.walk;
        o_busy      = (r_step != STEP_IDLE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step <= STEP_IDLE;
        end else begin
            r_step <= n_step;
        end
    end

endmodule

`default_nettype wire

/* src/lr_dp.sv */
// ----------------------------------------------------------------------------
// lr_dp
// Coordinate, delta and error registers with the Bresenham update and result beat.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_dp (
    input  wire logic                         i_clk,
    input  wire logic                         i_rst_n,
    input  wire lr_pkg::t_ctl                 i_ctl,
    input  wire logic [lr_pkg::COORD_W-1:0]   i_start_x,
    input  wire logic [lr_pkg::COORD_W-1:0]   i_start_y,
    input  wire logic [lr_pkg::COORD_W-1:0]   i_end_x,
    input  wire logic [lr_pkg::COORD_W-1:0]   i_end_y,
    input  wire logic [lr_pkg::CFG_W-1:0]     i_width,
    input  wire logic [lr_pkg::CFG_W-1:0]     i_height,
    output lr_pkg::t_stat                     o_stat,
    output logic                              o_pixel_valid,
    output logic [lr_pkg::COORD_W-1:0]        o_pixel_x,
    output logic [lr_pkg::COORD_W-1:0]        o_pixel_y,
    output logic                              o_visible,
    output logic                              o_last
);
    import lr_pkg::*;

    logic [COORD_W-1:0]     r_x, r_y, r_tx, r_ty, r_dx;
    logic signed [DY_W-1:0] r_dy;
    logic                   r_sx, r_sy;
    logic signed [ERR_W-1:0] r_err;

    logic [COORD_W-1:0]      w_adx, w_ady;
    logic signed [ERR_W:0]   w_e2;
    logic                    w_mx, w_my, w_done;
    logic signed [ERR_W-1:0] w_dx_e, w_dy_e, w_err_n;

    always_comb begin
        w_adx   = (r_tx >= r_x) ? (r_tx - r_x) : (r_x - r_tx);
        w_ady   = (r_ty >= r_y) ? (r_ty - r_y) : (r_y - r_ty);
        w_dx_e  = $signed({3'b000, r_dx});
        w_dy_e  = ERR_W'(r_dy);
        w_e2    = {r_err, 1'b0};
        w_mx    = (w_e2 >= (ERR_W+1)'(r_dy));
        w_my    = (w_e2 <= (ERR_W+1)'(w_dx_e));
        w_err_n = r_err + (w_mx ? w_dy_e : '0) + (w_my ? w_dx_e : '0);
        w_done  = (r_x == r_tx) && (r_y == r_ty);
        o_stat.done = w_done;
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.ld) begin
            r_x  <= i_start_x;
            r_y  <= i_start_y;
            r_tx <= i_end_x;
            r_ty <= i_end_y;
        end else if (i_ctl.setup) begin
            r_dx  <= w_adx;
            r_dy  <= -$signed({1'b0, w_ady});
            r_sx  <= (r_x < r_tx);
            r_sy  <= (r_y < r_ty);
            r_err <= $signed({3'b000, w_adx}) - $signed({3'b000, w_ady});
        end else if (i_ctl.walk) begin
            if (w_mx) begin
                r_x <= r_sx ? (r_x + 1'b1) : (r_x - 1'b1);
            end
            if (w_my) begin
                r_y <= r_sy ? (r_y + 1'b1) : (r_y - 1'b1);
            end
            r_err <= w_err_n;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.emit) begin
            o_pixel_x <= r_x;
            o_pixel_y <= r_y;
            o_visible <= ({1'b0, r_x} < i_width) && ({1'b0, r_y} < i_height);
            o_last    <= w_done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_pixel_valid <= 1'b0;
        end else begin
            o_pixel_valid <= i_ctl.emit;
        end
    end

endmodule

`default_nettype wire

/* src/line_rasterizer.sv */
// ----------------------------------------------------------------------------
// line_rasterizer
// All-octant Bresenham line walker driven by a microprogrammed sequencer.
// The first pixel beat is registered from the first walk step, after the setup step.
// Throughput: one pixel per cycle during the walk; a line holds busy through the setup
// step and all its walk steps, set by the single-step walk loop of the microprogram.
// Results are strobed for one cycle; the receiver cannot stall.
// Reset (synchronous, active low) returns the sequencer to idle and restores
// screen width 64 and height 40.
// ----------------------------------------------------------------------------
`default_nettype none

module line_rasterizer (
    input  wire logic                             i_clk,
    input  wire logic                             i_rst_n,
    input  wire logic                             start,
    output logic                                  busy,
    input  wire logic [lr_pkg::COORD_W-1:0]       i_start_x,
    input  wire logic [lr_pkg::COORD_W-1:0]       i_start_y,
    input  wire logic [lr_pkg::COORD_W-1:0]       i_end_x,
    input  wire logic [lr_pkg::COORD_W-1:0]       i_end_y,
    input  wire logic                             i_cfg_valid,
    output logic                                  o_cfg_ready,
    input  wire logic [lr_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire logic [lr_pkg::CFG_W-1:0]         i_cfg_data,
    output logic                                  o_pixel_valid,
    output logic [lr_pkg::COORD_W-1:0]            o_pixel_x,
    output logic [lr_pkg::COORD_W-1:0]            o_pixel_y,
    output logic                                  o_visible,
    output logic                                  o_last
);
    import lr_pkg::*;

    t_ctl              w_ctl;
    t_stat             w_stat;
    logic              w_busy;
    logic [CFG_W-1:0]  r_width, r_height;

    assign o_cfg_ready = 1'b1;
    assign busy        = w_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SCREEN_WIDTH:  r_width  <= i_cfg_data;
                REG_SCREEN_HEIGHT: r_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    lr_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (start),
        .i_stat  (w_stat),
        .o_ctl   (w_ctl),
        .o_busy  (w_busy)
    );

    lr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_start_x     (i_start_x),
        .i_start_y     (i_start_y),
        .i_end_x       (i_end_x),
        .i_end_y       (i_end_y),
        .i_width       (r_width),
        .i_height      (r_height),
        .o_stat        (w_stat),
        .o_pixel_valid (o_pixel_valid),
        .o_pixel_x     (o_pixel_x),
        .o_pixel_y     (o_pixel_y),
        .o_visible     (o_visible),
        .o_last        (o_last)
    );

endmodule

`default_nettype wire

/* src/lr_checker.sv */
// ----------------------------------------------------------------------------
// lr_checker
// Port-level checks on the command and pixel beat sequence.
// ----------------------------------------------------------------------------
`default_nettype none

module lr_checker (
    input wire logic                       i_clk,
    input wire logic                       i_rst_n,
    input wire logic                       start,
    input wire logic                       busy,
    input wire logic                       o_pixel_valid,
    input wire logic [lr_pkg::COORD_W-1:0] o_pixel_x,
    input wire logic [lr_pkg::COORD_W-1:0] o_pixel_y,
    input wire logic                       o_last
);
    import lr_pkg::*;

    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy not raised after accepted command");

    a_setup_gap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> !o_pixel_valid)
        else $error("pixel beat during setup step");

    a_run_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel_valid && !o_last) |-> busy)
        else $error("non-final pixel beat while idle");

    a_run_cont: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel_valid && !o_last) |=> o_pixel_valid)
        else $error("pixel run broken before last beat");

    a_step_adj: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_pixel_valid && !o_last) |=>
        (((o_pixel_x == $past(o_pixel_x)) || (o_pixel_x == $past(o_pixel_x) + 1'b1)
          || (o_pixel_x == $past(o_pixel_x) - 1'b1))
         && ((o_pixel_y == $past(o_pixel_y)) || (o_pixel_y == $past(o_pixel_y) + 1'b1)
          || (o_pixel_y == $past(o_pixel_y) - 1'b1))))
        else $error("pixel jumped by more than one");

endmodule

bind line_rasterizer lr_checker u_lr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .start         (start),
    .busy          (busy),
    .o_pixel_valid (o_pixel_valid),
    .o_pixel_x     (o_pixel_x),
    .o_pixel_y     (o_pixel_y),
    .o_last        (o_last)
);

`default_nettype wire

/* dv/tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb
// Line rasterizer check: feeds line commands and screen size writes, traces
// each line with an all-octant Bresenham walk and compares every pixel beat.
// ----------------------------------------------------------------------------
module tb;
    import lr_pkg::*;

    localparam int STALL_LIMIT   = 4000;
    localparam int TAIL_CYCLES   = 80;
    localparam int SETTLE_CYCLES = 4;
    localparam int PHASES        = 6;
    localparam int PHASE_LINES   = 52;
    localparam int RUSH_FIRST    = 100;
    localparam int RUSH_LAST     = 180;

    localparam logic [CFG_IDX_W-1:0] REG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SPARE_B = 2'd3;

    typedef logic [COORD_W-1:0] t_coord;

    typedef struct {
        bit                   is_reg;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]     reg_data;
        t_coord               x0, y0, x1, y1;
    } t_cmd;

    typedef struct {
        t_coord x, y;
        logic   vis, last;
    } t_pixel;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 start = 1'b0;
    logic                 busy;
    t_coord               i_start_x = '0;
    t_coord               i_start_y = '0;
    t_coord               i_end_x = '0;
    t_coord               i_end_y = '0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [CFG_W-1:0]     i_cfg_data = '0;
    logic                 o_pixel_valid;
    t_coord               o_pixel_x, o_pixel_y;
    logic                 o_visible, o_last;

    t_cmd             cmd_queue[$];
    t_pixel           line_pixels[$];
    logic [CFG_W-1:0] width_reg = WIDTH_RST;
    logic [CFG_W-1:0] height_reg = HEIGHT_RST;
    int               fail_count = 0;
    int               lines_sent = 0;
    int               settle_cnt = 0;
    int               stall_cnt = 0;
    bit               line_taken, reg_taken, idle, next_start, next_reg;
    t_cmd             head;
    t_pixel           want;

    line_rasterizer dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .start        (start),
        .busy         (busy),
        .i_start_x    (i_start_x),
        .i_start_y    (i_start_y),
        .i_end_x      (i_end_x),
        .i_end_y      (i_end_y),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .o_pixel_valid(o_pixel_valid),
        .o_pixel_x    (o_pixel_x),
        .o_pixel_y    (o_pixel_y),
        .o_visible    (o_visible),
        .o_last       (o_last)
    );

    initial begin
        forever #5 i_clk = ~i_clk;
    end

    function automatic void trace_line(input t_coord ax, ay, bx, by);
        int     x, y, tx, ty, dx, dy, sx, sy, err, e2, n;
        t_pixel p;
        x = ax;
        y = ay;
        tx = bx;
        ty = by;
        dx = (tx > x) ? tx - x : x - tx;
        dy = -((ty > y) ? ty - y : y - ty);
        sx = (x < tx) ? 1 : -1;
        sy = (y < ty) ? 1 : -1;
        err = dx + dy;
        n = 0;
        while (n < MAX_COORD) begin
            p.x = x[COORD_W-1:0];
            p.y = y[COORD_W-1:0];
            p.vis = (x < int'(width_reg)) && (y < int'(height_reg));
            p.last = (x == tx) && (y == ty);
            line_pixels.push_back(p);
            n++;
            if (p.last) break;
            e2 = 2 * err;
            if (e2 >= dy) begin
                err += dy;
                x += sx;
            end
            if (e2 <= dx) begin
                err += dx;
                y += sy;
            end
        end
    endfunction

    function automatic t_coord pin(input int c);
        return (c < 0) ? t_coord'(0) : ((c > MAX_COORD - 1) ? t_coord'(MAX_COORD - 1)
                                                             : t_coord'(c));
    endfunction

    function automatic void add_line(input int x0, y0, x1, y1);
        t_cmd c;
        c = '{is_reg: 1'b0, reg_idx: '0, reg_data: '0,
              x0: pin(x0), y0: pin(y0), x1: pin(x1), y1: pin(y1)};
        cmd_queue.push_back(c);
    endfunction

    function automatic void add_reg(input logic [CFG_IDX_W-1:0] idx, input int data);
        t_cmd c;
        c = '{is_reg: 1'b1, reg_idx: idx, reg_data: CFG_W'(data),
              x0: '0, y0: '0, x1: '0, y1: '0};
        cmd_queue.push_back(c);
    endfunction

    task automatic check_field(input string name, input logic [7:0] exp_v, act_v);
        if (act_v !== exp_v) begin
            $display("%0t: %s expected %0d got %0d", $time, name, exp_v, act_v);
            fail_count++;
        end
    endtask

    // driver: line commands on start/busy, register beats on the cfg channel
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            start <= 1'b0;
            i_cfg_valid <= 1'b0;
            width_reg = WIDTH_RST;
            height_reg = HEIGHT_RST;
            settle_cnt = 0;
        end else begin
            line_taken = start && !busy;
            reg_taken = i_cfg_valid && o_cfg_ready;
            if (line_taken) begin
                trace_line(i_start_x, i_start_y, i_end_x, i_end_y);
                lines_sent++;
                void'(cmd_queue.pop_front());
            end
            if (reg_taken) begin
                case (i_cfg_index)
                    REG_SCREEN_WIDTH:  width_reg = i_cfg_data;
                    REG_SCREEN_HEIGHT: height_reg = i_cfg_data;
                    default: ;
                endcase
                void'(cmd_queue.pop_front());
            end
            if (line_pixels.size() == 0 && !busy && !start && !line_taken)
                settle_cnt++;
            else
                settle_cnt = 0;

            idle = (lines_sent < RUSH_FIRST || lines_sent >= RUSH_LAST) &&
                   ($urandom_range(0, 99) < 34);
            next_start = 1'b0;
            next_reg = 1'b0;
            if (cmd_queue.size() != 0) begin
                head = cmd_queue[0];
                if (head.is_reg) begin
                    if (i_cfg_valid && !reg_taken) begin
                        next_reg = 1'b1;
                    end else if (settle_cnt >= SETTLE_CYCLES && !idle) begin
                        next_reg = 1'b1;
                        i_cfg_index <= head.reg_idx;
                        i_cfg_data <= head.reg_data;
                    end
                end else begin
                    if (start && !line_taken) begin
                        next_start = 1'b1;
                    end else if (!idle) begin
                        next_start = 1'b1;
                        i_start_x <= head.x0;
                        i_start_y <= head.y0;
                        i_end_x <= head.x1;
                        i_end_y <= head.y1;
                    end
                end
            end
            start <= next_start;
            i_cfg_valid <= next_reg;
        end
    end

    // monitor: every pixel beat against the oldest traced pixel
    always @(posedge i_clk) begin
        if (i_rst_n && o_pixel_valid) begin
            if (line_pixels.size() == 0) begin
                $display("%0t: pixel beat with none expected, got x=%0d y=%0d vis=%0d last=%0d",
                         $time, o_pixel_x, o_pixel_y, o_visible, o_last);
                fail_count++;
            end else begin
                want = line_pixels.pop_front();
                check_field("pixel_x", want.x, o_pixel_x);
                check_field("pixel_y", want.y, o_pixel_y);
                check_field("visible", want.vis, o_visible);
                check_field("last", want.last, o_last);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (start && !busy) || (i_cfg_valid && o_cfg_ready) || o_pixel_valid)
            stall_cnt <= 0;
        else
            stall_cnt <= stall_cnt + 1;
        if (stall_cnt >= STALL_LIMIT) begin
            $display("%0t: no beat for %0d cycles", $time, stall_cnt);
            $display("Test completed with failures");
            $finish;
        end
    end

    initial begin
        int p, i, x0, y0, x1, y1;
        int plan_w[PHASES];
        int plan_h[PHASES];
        plan_w = '{64, 0, 1, 127, 64, 45};
        plan_h = '{40, 0, 1, 127, 64, 17};

        add_line(0, 0, 0, 0);
        add_line(63, 63, 63, 63);
        add_line(0, 0, 63, 0);
        add_line(63, 0, 0, 0);
        add_line(0, 0, 0, 63);
        add_line(63, 63, 63, 0);
        add_line(0, 0, 63, 63);
        add_line(63, 63, 0, 0);
        add_line(63, 0, 0, 63);
        add_line(0, 63, 63, 0);
        add_line(32, 32, 40, 35);
        add_line(32, 32, 35, 40);
        add_line(32, 32, 29, 40);
        add_line(32, 32, 24, 35);
        add_line(32, 32, 24, 29);
        add_line(32, 32, 29, 24);
        add_line(32, 32, 35, 24);
        add_line(32, 32, 40, 29);
        add_line(62, 38, 63, 41);
        add_line(0, 39, 1, 40);
        add_line(0, 21, 42, 63);

        for (p = 0; p < PHASES; p++) begin
            if (p != 0) begin
                add_reg(REG_SCREEN_WIDTH, plan_w[p]);
                add_reg(REG_SCREEN_HEIGHT, plan_h[p]);
            end
            if (p == 3) begin
                add_reg(REG_SPARE_A, $urandom_range(0, 127));
                add_reg(REG_SPARE_B, 0);
            end
            for (i = 0; i < PHASE_LINES; i++) begin
                x0 = $urandom_range(0, 63);
                y0 = $urandom_range(0, 63);
                case ($urandom_range(0, 9))
                    0: begin
                        x1 = x0;
                        y1 = y0;
                    end
                    1, 2, 3: begin
                        x1 = x0 + int'($urandom_range(0, 12)) - 6;
                        y1 = y0 + int'($urandom_range(0, 12)) - 6;
                    end
                    default: begin
                        x1 = $urandom_range(0, 63);
                        y1 = $urandom_range(0, 63);
                    end
                endcase
                add_line(x0, y0, x1, y1);
            end
        end

        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        while (cmd_queue.size() != 0 || line_pixels.size() != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (line_pixels.size() != 0) begin
            $display("%0t: %0d pixels never arrived", $time, line_pixels.size());
            fail_count++;
        end
        if (fail_count == 0)
            $display("Test completed successfully");
        else
            $display("Test completed with failures");
        $finish;
    end

endmodule
